@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/ntt4_pkg.sv @@
// ----------------------------------------------------------------------------
// ntt4_pkg
// Constants and types shared by the four-point NTT pipeline.
// ----------------------------------------------------------------------------
package ntt4_pkg;

  localparam int COEF_W = 14;
  localparam int PROD_W = 28;
  localparam int RED_W  = 16;
  localparam int MQ_W   = 30;
  localparam int ACC_W  = 31;

  localparam logic [COEF_W-1:0] MOD_Q        = 14'd12289;
  localparam logic [RED_W-1:0]  MOD_QNEG_INV = 16'd12287;

  localparam logic [COEF_W-1:0] TW_FIRST_RST  = 14'd7888;
  localparam logic [COEF_W-1:0] TW_SECOND_RST = 14'd11060;
  localparam logic [COEF_W-1:0] TW_THIRD_RST  = 14'd11208;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_TW_FIRST  = 2'd0;
  localparam logic [1:0] REG_TW_SECOND = 2'd1;
  localparam logic [1:0] REG_TW_THIRD  = 2'd2;

  // butterfly pipeline depth
  localparam int BF_STAGES = 5;

  typedef logic [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t tw_first;
    coef_t tw_second;
    coef_t tw_third;
  } twiddles_t;

endpackage

@@ hdl/ntt4_if.sv @@
// ----------------------------------------------------------------------------
// ntt4 channel interfaces
// Valid/ready channels for coefficient groups and transformed results.
// ----------------------------------------------------------------------------
interface ntt4_in_if;
  logic          valid;
  logic          ready;
  ntt4_pkg::coef_t coef0;
  ntt4_pkg::coef_t coef1;
  ntt4_pkg::coef_t coef2;
  ntt4_pkg::coef_t coef3;

  modport source (output valid, output coef0, output coef1, output coef2,
                  output coef3, input ready);
  modport sink (input valid, input coef0, input coef1, input coef2,
                input coef3, output ready);
endinterface

interface ntt4_out_if;
  logic          valid;
  logic          ready;
  ntt4_pkg::coef_t res0;
  ntt4_pkg::coef_t res1;
  ntt4_pkg::coef_t res2;
  ntt4_pkg::coef_t res3;
  logic          range_error;

  modport source (output valid, output res0, output res1, output res2,
                  output res3, output range_error, input ready);
  modport sink (input valid, input res0, input res1, input res2,
                input res3, input range_error, output ready);
endinterface

@@ hdl/ntt4_montgomery_mod_q.sv @@
// Throughput: one coefficient group per cycle; two butterfly layers of five
// stages each plus an output register form the pipeline.
// The whole pipeline holds while a finished result waits to be taken.
// Reset clears the valid bits and loads the default twiddles.
// ----------------------------------------------------------------------------
// ntt4_montgomery_mod_q
// Pipelined four-point NTT modulo 12289 with APB-programmable twiddles.
// ----------------------------------------------------------------------------
module ntt4_montgomery_mod_q (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ntt4_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  ntt4_in_if.sink                     samples,
  ntt4_out_if.source                  results
);

  localparam int LAT = 2 * ntt4_pkg::BF_STAGES + 1;

  ntt4_pkg::twiddles_t twiddles;
  logic                en;
  logic                bad_in;
  logic [LAT-1:0]      vld;
  logic [LAT-2:0]      bad;
  ntt4_pkg::coef_t     s0, s1, s2, s3, r0, r1, r2, r3;

  ntt4_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .twiddles (twiddles)
  );

  assign en            = !vld[LAT-1] || results.ready;
  assign samples.ready = en;
  assign results.valid = vld[LAT-1];

  assign bad_in = (samples.coef0 >= ntt4_pkg::MOD_Q) || (samples.coef1 >= ntt4_pkg::MOD_Q)
               || (samples.coef2 >= ntt4_pkg::MOD_Q) || (samples.coef3 >= ntt4_pkg::MOD_Q);

  ntt4_bfly u_bf_a (.clk(clk), .en(en), .top(samples.coef0), .bot(samples.coef2),
                    .tw(twiddles.tw_first), .sum(s0), .diff(s2));
  ntt4_bfly u_bf_b (.clk(clk), .en(en), .top(samples.coef1), .bot(samples.coef3),
                    .tw(twiddles.tw_first), .sum(s1), .diff(s3));
  ntt4_bfly u_bf_c (.clk(clk), .en(en), .top(s0), .bot(s1),
                    .tw(twiddles.tw_second), .sum(r0), .diff(r1));
  ntt4_bfly u_bf_d (.clk(clk), .en(en), .top(s2), .bot(s3),
                    .tw(twiddles.tw_third), .sum(r2), .diff(r3));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], samples.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad <= {bad[LAT-3:0], bad_in};
      results.range_error <= bad[LAT-2];
      results.res0 <= bad[LAT-2] ? '0 : r0;
      results.res1 <= bad[LAT-2] ? '0 : r1;
      results.res2 <= bad[LAT-2] ? '0 : r2;
      results.res3 <= bad[LAT-2] ? '0 : r3;
    end
  end

endmodule

@@ hdl/ntt4_cfg.sv @@
// ----------------------------------------------------------------------------
// ntt4_cfg
// APB register file holding the three Montgomery-form twiddles.
// ----------------------------------------------------------------------------
module ntt4_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ntt4_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ntt4_pkg::twiddles_t          twiddles
);

  logic [1:0] index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      twiddles.tw_first  <= ntt4_pkg::TW_FIRST_RST;
      twiddles.tw_second <= ntt4_pkg::TW_SECOND_RST;
      twiddles.tw_third  <= ntt4_pkg::TW_THIRD_RST;
    end else if (wr) begin
      case (index)
        ntt4_pkg::REG_TW_FIRST:  twiddles.tw_first  <= pwdata[ntt4_pkg::COEF_W-1:0];
        ntt4_pkg::REG_TW_SECOND: twiddles.tw_second <= pwdata[ntt4_pkg::COEF_W-1:0];
        ntt4_pkg::REG_TW_THIRD:  twiddles.tw_third  <= pwdata[ntt4_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      ntt4_pkg::REG_TW_FIRST:  prdata = 32'(twiddles.tw_first);
      ntt4_pkg::REG_TW_SECOND: prdata = 32'(twiddles.tw_second);
      ntt4_pkg::REG_TW_THIRD:  prdata = 32'(twiddles.tw_third);
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/ntt4_bfly.sv @@
// ----------------------------------------------------------------------------
// ntt4_bfly
// Five-stage Montgomery butterfly: product, reduction factor, factor times q,
// reduce and subtract, then modular sum and difference.
// ----------------------------------------------------------------------------
module ntt4_bfly (
  input  logic            clk,
  input  logic            en,
  input  ntt4_pkg::coef_t top,
  input  ntt4_pkg::coef_t bot,
  input  ntt4_pkg::coef_t tw,
  output ntt4_pkg::coef_t sum,
  output ntt4_pkg::coef_t diff
);

  logic [ntt4_pkg::PROD_W-1:0] prod1, prod2, prod3;
  logic [ntt4_pkg::RED_W-1:0]  m2;
  logic [ntt4_pkg::MQ_W-1:0]   mq3;
  ntt4_pkg::coef_t             top1, top2, top3, top4, prod4;

  logic [ntt4_pkg::ACC_W-1:0]  acc;
  logic [ntt4_pkg::COEF_W:0]   t_raw, t_red;
  logic [ntt4_pkg::COEF_W:0]   s_raw, s_red, d_val;
  logic [ntt4_pkg::PROD_W+ntt4_pkg::RED_W-1:0] m_full;

  assign m_full = (ntt4_pkg::PROD_W+ntt4_pkg::RED_W)'(prod1[ntt4_pkg::RED_W-1:0])
                * (ntt4_pkg::PROD_W+ntt4_pkg::RED_W)'(ntt4_pkg::MOD_QNEG_INV);
  assign acc    = ntt4_pkg::ACC_W'(prod3) + ntt4_pkg::ACC_W'(mq3);
  assign t_raw  = acc[ntt4_pkg::ACC_W-1:ntt4_pkg::RED_W];
  assign t_red  = (t_raw >= 15'(ntt4_pkg::MOD_Q)) ? t_raw - 15'(ntt4_pkg::MOD_Q) : t_raw;

  assign s_raw = 15'(top4) + 15'(prod4);
  assign s_red = (s_raw >= 15'(ntt4_pkg::MOD_Q)) ? s_raw - 15'(ntt4_pkg::MOD_Q) : s_raw;
  assign d_val = (top4 >= prod4) ? 15'(top4) - 15'(prod4)
                                 : 15'(top4) + 15'(ntt4_pkg::MOD_Q) - 15'(prod4);

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= ntt4_pkg::PROD_W'(bot) * ntt4_pkg::PROD_W'(tw);
      top1  <= top;
      m2    <= m_full[ntt4_pkg::RED_W-1:0];
      prod2 <= prod1;
      top2  <= top1;
      mq3   <= ntt4_pkg::MQ_W'(m2) * ntt4_pkg::MQ_W'(ntt4_pkg::MOD_Q);
      prod3 <= prod2;
      top3  <= top2;
      prod4 <= t_red[ntt4_pkg::COEF_W-1:0];
      top4  <= top3;
      sum   <= s_red[ntt4_pkg::COEF_W-1:0];
      diff  <= d_val[ntt4_pkg::COEF_W-1:0];
    end
  end

endmodule

@@ hdl/ntt4_chk.sv @@
// ----------------------------------------------------------------------------
// ntt4_chk
// Port-level checks for the NTT pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntt4_chk (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ntt4_pkg::coef_t res0,
  input ntt4_pkg::coef_t res1,
  input ntt4_pkg::coef_t res2,
  input ntt4_pkg::coef_t res3,
  input logic            range_error
);

  logic res_in_range;
  logic res_zero;
  logic out_held;

  assign res_in_range = (res0 < ntt4_pkg::MOD_Q) && (res1 < ntt4_pkg::MOD_Q)
                     && (res2 < ntt4_pkg::MOD_Q) && (res3 < ntt4_pkg::MOD_Q);
  assign res_zero     = (res0 == '0) && (res1 == '0) && (res2 == '0) && (res3 == '0);
  assign out_held     = out_valid && !out_ready;

  `ASSERT_IMP(a_res_below_q, clk, rst, out_valid, res_in_range)
  `ASSERT_IMP(a_err_zeroes, clk, rst, out_valid && range_error, res_zero)
  `ASSERT_IMP(a_stall_only_on_hold, clk, rst, !in_ready, out_held)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(res0) && $stable(range_error))

endmodule

bind ntt4_montgomery_mod_q ntt4_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .res0        (results.res0),
  .res1        (results.res1),
  .res2        (results.res2),
  .res3        (results.res3),
  .range_error (results.range_error)
);
